/* design/assert_macros.svh */
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CHK_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("check failed");

// implication whose consequent is checked at the next clock edge
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

/* design/rls_pkg.sv */
package rls_pkg;

	localparam int STEER_WIDTH = 16;
	localparam int TIMER_WIDTH = 16;
	localparam int CFG_WIDTH = 16;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int STATE_WIDTH = 4;
	localparam int CMP_WIDTH = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

	// 20 s move and homing window at a 250 ms tick
	localparam int TIMEOUT_SECONDS = 20;
	localparam int MS_PER_SECOND = 1000;
	localparam int TICK_MS = 250;
	localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET =
		CFG_WIDTH'(TIMEOUT_SECONDS * MS_PER_SECOND / TICK_MS);

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_MOVE_TIMEOUT   = 2'd0,
		REG_HOMING_TIMEOUT = 2'd1
	} reg_index_t;

	typedef enum logic [STATE_WIDTH-1:0] {
		ST_INIT       = 4'd0,
		ST_RETRACTED  = 4'd1,
		ST_RETRACTING = 4'd2,
		ST_HOMING     = 4'd3,
		ST_EXTENDED   = 4'd4,
		ST_EXTENDING  = 4'd5,
		ST_NOPOS      = 4'd6,
		ST_ESTOP      = 4'd7,
		ST_MAINT      = 4'd8
	} ctrl_state_t;

endpackage

/* design/retractable_lift_sequencer.sv */
// retractable lift sequencer
// input channel (in_valid / in_ready) carries one control tick per item: lift
// end sensors, up and down buttons, emergency stop, maintenance request and
// status, azimuth home flag and a signed steering value
// output channel (out_valid / out_ready) returns one result item per tick:
// state code, held drive and enable outputs, entry pulses and steering
// each item passes the input register, then the state update into the result
// register; throughput: one item per cycle while the receiver takes results
// and does not stall; the controller state is updated once per item in a
// single pass of next-state logic, which sets the rate
// a stalled receiver holds the result register and the input register fills;
// the block keeps taking items until both are occupied
// configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once;
// index 0 is the move timeout, index 1 the homing timeout, others are ignored
// reset: state init, tick counter and maintenance latch cleared, all drives
// and enables off, both timeouts at 80 ticks, no items held
module retractable_lift_sequencer (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [rls_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [rls_pkg::CFG_WIDTH-1:0]          cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   lift_top_seen,
	input  logic                                   lift_bottom_seen,
	input  logic                                   up_button,
	input  logic                                   down_button,
	input  logic                                   estop_active,
	input  logic                                   maintenance_request,
	input  logic                                   maintenance_active,
	input  logic                                   azi_at_home,
	input  logic signed [rls_pkg::STEER_WIDTH-1:0] steer_value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [rls_pkg::STATE_WIDTH-1:0]        state_code,
	output logic                                   lift_power_on,
	output logic                                   lift_up_drive,
	output logic                                   lift_down_drive,
	output logic                                   thruster_enable,
	output logic                                   azi_drive_on,
	output logic                                   azi_analog_on,
	output logic                                   maintenance_start,
	output logic                                   retracted_pulse,
	output logic                                   extended_pulse,
	output logic                                   steer_valid,
	output logic signed [rls_pkg::STEER_WIDTH-1:0] steer_out
);
	import rls_pkg::*;

	// configuration registers
	logic [CFG_WIDTH-1:0] move_timeout_q;
	logic [CFG_WIDTH-1:0] homing_timeout_q;

	// input register
	logic                          valid_s1;
	logic                          up_s_s1, down_s_s1, up_b_s1, down_b_s1;
	logic                          estop_s1, m_req_s1, m_act_s1, az_home_s1;
	logic signed [STEER_WIDTH-1:0] steer_s1;

	// controller state
	ctrl_state_t            state_q, state_d;
	logic [TIMER_WIDTH-1:0] ticks_q, ticks_d, ticks_inc;
	logic                   latch_q, latch_d, latch_eff;
	logic                   lift_en_q, up_drv_q, down_drv_q;
	logic                   thr_en_q, az_en_q, an_en_q;
	logic                   lift_en_d, up_drv_d, down_drv_d;
	logic                   thr_en_d, az_en_d, an_en_d;

	// result register
	logic                          out_valid_q;
	logic                          p_maint_q, p_retr_q, p_ext_q, steer_ok_q;
	logic signed [STEER_WIDTH-1:0] steer_q;

	logic                          advance;
	logic                          take;
	ctrl_state_t                   next_state;
	logic                          move_to, homing_to;
	logic                          p_maint_d, p_retr_d, p_ext_d, steer_ok_d;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_timeout_q   <= TIMEOUT_RESET;
			homing_timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_MOVE_TIMEOUT)
				move_timeout_q <= cfg_wdata;
			else if (cfg_index == REG_HOMING_TIMEOUT)
				homing_timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			up_s_s1    <= lift_top_seen;
			down_s_s1  <= lift_bottom_seen;
			up_b_s1    <= up_button;
			down_b_s1  <= down_button;
			estop_s1   <= estop_active;
			m_req_s1   <= maintenance_request;
			m_act_s1   <= maintenance_active;
			az_home_s1 <= azi_at_home;
			steer_s1   <= steer_value;
		end
	end

	// saturating tick count and the timeout compares
	always_comb begin
		ticks_inc = (ticks_q == {TIMER_WIDTH{1'b1}}) ? ticks_q : ticks_q + 1'b1;
		latch_eff = latch_q || m_req_s1;
		move_to   = CMP_WIDTH'(ticks_inc) >= CMP_WIDTH'(move_timeout_q);
		homing_to = CMP_WIDTH'(ticks_inc) >= CMP_WIDTH'(homing_timeout_q);
	end

	// transition choice: first condition in order wins
	always_comb begin
		take       = 1'b1;
		next_state = ST_NOPOS;
		unique case (state_q)
			ST_NOPOS: begin
				priority if (down_s_s1 && !up_s_s1) next_state = ST_EXTENDED;
				else if (down_b_s1)                 next_state = ST_EXTENDING;
				else if (up_b_s1)                   next_state = ST_HOMING;
				else if (up_s_s1 && !down_s_s1)     next_state = ST_RETRACTED;
				else if (estop_s1)                  next_state = ST_ESTOP;
				else if (latch_eff)                 next_state = ST_MAINT;
				else                                take = 1'b0;
			end
			ST_HOMING: begin
				priority if (az_home_s1) next_state = ST_RETRACTING;
				else if (homing_to)      next_state = ST_NOPOS;
				else if (estop_s1)       next_state = ST_ESTOP;
				else                     take = 1'b0;
			end
			ST_RETRACTING: begin
				priority if (up_s_s1) next_state = ST_RETRACTED;
				else if (move_to)     next_state = ST_NOPOS;
				else if (estop_s1)    next_state = ST_ESTOP;
				else                  take = 1'b0;
			end
			ST_RETRACTED: begin
				priority if (down_b_s1) next_state = ST_EXTENDING;
				else if (!up_s_s1)      next_state = ST_NOPOS;
				else if (estop_s1)      next_state = ST_ESTOP;
				else if (latch_eff)     next_state = ST_MAINT;
				else                    take = 1'b0;
			end
			ST_EXTENDING: begin
				priority if (down_s_s1) next_state = ST_EXTENDED;
				else if (move_to)       next_state = ST_NOPOS;
				else if (estop_s1)      next_state = ST_ESTOP;
				else                    take = 1'b0;
			end
			ST_EXTENDED: begin
				priority if (up_b_s1) next_state = ST_HOMING;
				else if (!down_s_s1)  next_state = ST_NOPOS;
				else if (estop_s1)    next_state = ST_ESTOP;
				else if (latch_eff)   next_state = ST_MAINT;
				else                  take = 1'b0;
			end
			ST_ESTOP: begin
				if (estop_s1)
					take = 1'b0;
			end
			ST_MAINT: begin
				if (m_act_s1)
					take = 1'b0;
			end
			default: begin
				// init, and any stray code, falls to no position
				next_state = ST_NOPOS;
			end
		endcase
	end

	// entry actions: only the named outputs change
	always_comb begin
		state_d    = state_q;
		ticks_d    = ticks_inc;
		latch_d    = latch_eff;
		lift_en_d  = lift_en_q;
		up_drv_d   = up_drv_q;
		down_drv_d = down_drv_q;
		thr_en_d   = thr_en_q;
		az_en_d    = az_en_q;
		an_en_d    = an_en_q;
		p_maint_d  = 1'b0;
		p_retr_d   = 1'b0;
		p_ext_d    = 1'b0;
		if (take) begin
			state_d = next_state;
			ticks_d = '0;
			unique case (next_state)
				ST_NOPOS: begin
					up_drv_d   = 1'b0;
					down_drv_d = 1'b0;
					if (!down_s_s1) begin
						thr_en_d = 1'b0;
						az_en_d  = 1'b0;
						an_en_d  = 1'b0;
					end
				end
				ST_HOMING: begin
					thr_en_d = 1'b0;
					az_en_d  = 1'b0;
					an_en_d  = 1'b0;
				end
				ST_RETRACTING: begin
					thr_en_d   = 1'b0;
					az_en_d    = 1'b0;
					an_en_d    = 1'b0;
					lift_en_d  = 1'b1;
					up_drv_d   = 1'b1;
					down_drv_d = 1'b0;
				end
				ST_RETRACTED: begin
					thr_en_d   = 1'b0;
					lift_en_d  = 1'b0;
					up_drv_d   = 1'b0;
					down_drv_d = 1'b0;
					p_retr_d   = 1'b1;
				end
				ST_EXTENDING: begin
					thr_en_d   = 1'b0;
					az_en_d    = 1'b0;
					an_en_d    = 1'b0;
					lift_en_d  = 1'b1;
					up_drv_d   = 1'b0;
					down_drv_d = 1'b1;
				end
				ST_EXTENDED: begin
					up_drv_d   = 1'b0;
					down_drv_d = 1'b0;
					thr_en_d   = 1'b1;
					az_en_d    = 1'b1;
					an_en_d    = 1'b1;
					p_ext_d    = 1'b1;
				end
				ST_MAINT: begin
					latch_d    = 1'b0;
					thr_en_d   = 1'b0;
					az_en_d    = 1'b0;
					an_en_d    = 1'b0;
					lift_en_d  = 1'b0;
					up_drv_d   = 1'b0;
					down_drv_d = 1'b0;
					p_maint_d  = 1'b1;
				end
				default: begin
					// init and emergency stop: everything off
					thr_en_d   = 1'b0;
					az_en_d    = 1'b0;
					an_en_d    = 1'b0;
					lift_en_d  = 1'b0;
					up_drv_d   = 1'b0;
					down_drv_d = 1'b0;
				end
			endcase
		end
		// steering goes through only with the azimuth live, the lift down and no maintenance active
		steer_ok_d = !m_act_s1 && down_s_s1 && az_en_d && an_en_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			ticks_q    <= '0;
			latch_q    <= 1'b0;
			lift_en_q  <= 1'b0;
			up_drv_q   <= 1'b0;
			down_drv_q <= 1'b0;
			thr_en_q   <= 1'b0;
			az_en_q    <= 1'b0;
			an_en_q    <= 1'b0;
		end else if (advance) begin
			state_q    <= state_d;
			ticks_q    <= ticks_d;
			latch_q    <= latch_d;
			lift_en_q  <= lift_en_d;
			up_drv_q   <= up_drv_d;
			down_drv_q <= down_drv_d;
			thr_en_q   <= thr_en_d;
			az_en_q    <= az_en_d;
			an_en_q    <= an_en_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			p_maint_q  <= p_maint_d;
			p_retr_q   <= p_retr_d;
			p_ext_q    <= p_ext_d;
			steer_ok_q <= steer_ok_d;
			steer_q    <= steer_ok_d ? steer_s1 : '0;
		end
	end

	// held outputs change only when a result is loaded, so they read straight
	// from the controller registers
	assign out_valid         = out_valid_q;
	assign state_code        = state_q;
	assign lift_power_on     = lift_en_q;
	assign lift_up_drive     = up_drv_q;
	assign lift_down_drive   = down_drv_q;
	assign thruster_enable   = thr_en_q;
	assign azi_drive_on      = az_en_q;
	assign azi_analog_on     = an_en_q;
	assign maintenance_start = p_maint_q;
	assign retracted_pulse   = p_retr_q;
	assign extended_pulse    = p_ext_q;
	assign steer_valid       = steer_ok_q;
	assign steer_out         = steer_q;

endmodule

/* design/rls_checker.sv */
`include "assert_macros.svh"

module rls_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic [rls_pkg::STATE_WIDTH-1:0]        state_code,
	input logic                                   lift_up_drive,
	input logic                                   lift_down_drive,
	input logic                                   maintenance_start,
	input logic                                   retracted_pulse,
	input logic                                   steer_valid,
	input logic signed [rls_pkg::STEER_WIDTH-1:0] steer_out
);
	import rls_pkg::*;

	// a waiting result holds still
	`CHK_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(state_code) && $stable(steer_out))
	// never drive the lift both ways
	`CHK_ALWAYS(a_drive_excl, clk, arst_n, !(lift_up_drive && lift_down_drive))
	// blocked steering reads as zero
	`CHK_ALWAYS(a_steer_zero, clk, arst_n, !(out_valid && !steer_valid) || steer_out == '0)
	// entry pulses match the state shown
	`CHK_ALWAYS(a_maint_pulse, clk, arst_n, !(out_valid && maintenance_start) || state_code == ST_MAINT)
	`CHK_ALWAYS(a_retr_pulse, clk, arst_n, !(out_valid && retracted_pulse) || (state_code == ST_RETRACTED && !lift_up_drive))

endmodule

bind retractable_lift_sequencer rls_checker u_rls_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.state_code        (state_code),
	.lift_up_drive     (lift_up_drive),
	.lift_down_drive   (lift_down_drive),
	.maintenance_start (maintenance_start),
	.retracted_pulse   (retracted_pulse),
	.steer_valid       (steer_valid),
	.steer_out         (steer_out)
);
